/* hw/rtl/sbfd_pkg.sv */
// ----------------------------------------------------------------------------
// sbfd_pkg
// shared types and constants of the serial button frame decoder
// ----------------------------------------------------------------------------
package sbfd_pkg;

    localparam int DEF_MAX_FRAME_LENGTH = 32;

    localparam logic [7:0] START_BYTE = 8'hFF;

    // command letters
    localparam logic [7:0] CH_N   = 8'h4E;
    localparam logic [7:0] CH_T   = 8'h54;
    localparam logic [7:0] CH_P   = 8'h50;
    localparam logic [7:0] CH_L   = 8'h4C;
    localparam logic [7:0] CH_S   = 8'h53;
    localparam logic [7:0] CH_R   = 8'h52;
    localparam logic [7:0] CH_M   = 8'h4D;
    localparam logic [7:0] CH_X   = 8'h58;
    localparam logic [7:0] CH_F   = 8'h46;
    localparam logic [7:0] CH_C   = 8'h43;
    localparam logic [7:0] CH_D   = 8'h44;
    localparam logic [7:0] CH_ON  = 8'h31;
    localparam logic [7:0] CH_OFF = 8'h30;

    typedef enum logic [1:0] {
        PHASE_WAIT = 2'd0,
        PHASE_LEN  = 2'd1,
        PHASE_DATA = 2'd2
    } phase_t;

    typedef enum logic [4:0] {
        EV_NEXT_TRACK = 5'd0,
        EV_PREV_TRACK = 5'd1,
        EV_PLAY       = 5'd2,
        EV_STOP       = 5'd3,
        EV_REPEAT_ON  = 5'd4,
        EV_REPEAT_OFF = 5'd5,
        EV_SHUFFLE_ON = 5'd6,
        EV_SHUFFLE_OFF = 5'd7,
        EV_FF_ON      = 5'd8,
        EV_FF_OFF     = 5'd9,
        EV_RW_ON      = 5'd10,
        EV_RW_OFF     = 5'd11,
        EV_SCAN_ON    = 5'd12,
        EV_SCAN_OFF   = 5'd13,
        EV_PREV_DISC  = 5'd14,
        EV_NEXT_DISC  = 5'd15,
        EV_UNKNOWN    = 5'd16
    } event_t;

    // mode flag bit positions
    localparam int FLAG_PLAY    = 0;
    localparam int FLAG_REPEAT  = 1;
    localparam int FLAG_SHUFFLE = 2;
    localparam int FLAG_FF      = 3;
    localparam int FLAG_RW      = 4;
    localparam int FLAG_SCAN    = 5;

    typedef struct packed {
        logic            done;
        logic [2:0][7:0] head;
        logic [7:0]      text_length;
    } frame_info_t;

    typedef struct packed {
        logic   valid;
        event_t code;
    } event_info_t;

endpackage

/* hw/rtl/sbfd_framer.sv */
// ----------------------------------------------------------------------------
// sbfd_framer
// frame phase tracking, length check and payload head capture
// ----------------------------------------------------------------------------
module sbfd_framer #(
    parameter int MAX_FRAME_LENGTH = sbfd_pkg::DEF_MAX_FRAME_LENGTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            rx_byte,
    output sbfd_pkg::frame_info_t info
);
    import sbfd_pkg::*;

    localparam logic [7:0] MaxLen = 8'(MAX_FRAME_LENGTH);

    phase_t          phase_reg, phase_next;
    logic [7:0]      frame_length_reg, frame_length_next;
    logic [7:0]      byte_index_reg, byte_index_next;
    logic [7:0]      text_length_reg, text_length_next;
    logic [2:0][7:0] head_reg, head_next;
    logic            last_byte;

    assign last_byte = ({1'b0, byte_index_reg} + 9'd1) == {1'b0, frame_length_reg};

    // next state
    always_comb
    begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        byte_index_next   = byte_index_reg;
        text_length_next  = text_length_reg;
        head_next         = head_reg;
        if (rx_byte == START_BYTE)
        begin
            phase_next = PHASE_LEN;
        end
        else
        begin
            case (phase_reg)
                PHASE_LEN:
                begin
                    frame_length_next = rx_byte;
                    if (rx_byte != 8'd0 && rx_byte <= MaxLen)
                    begin
                        byte_index_next  = 8'd0;
                        text_length_next = 8'd0;
                        phase_next       = PHASE_DATA;
                    end
                    else
                    begin
                        phase_next = PHASE_WAIT;
                    end
                end
                PHASE_DATA:
                begin
                    if (byte_index_reg < 8'd3)
                    begin
                        head_next[byte_index_reg[1:0]] = rx_byte;
                    end
                    // text runs up to the first zero byte
                    if (text_length_reg == byte_index_reg && rx_byte != 8'd0)
                    begin
                        text_length_next = byte_index_reg + 8'd1;
                    end
                    if (last_byte)
                    begin
                        phase_next = PHASE_WAIT;
                    end
                    else
                    begin
                        byte_index_next = byte_index_reg + 8'd1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        info.done        = (rx_byte != START_BYTE) && (phase_reg == PHASE_DATA) && last_byte;
        info.head        = head_next;
        info.text_length = text_length_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PHASE_WAIT;
            frame_length_reg <= 8'd0;
            byte_index_reg   <= 8'd0;
            text_length_reg  <= 8'd0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            byte_index_reg   <= byte_index_next;
            text_length_reg  <= text_length_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            head_reg <= head_next;
        end
    end

endmodule

/* hw/rtl/sbfd_decoder.sv */
// ----------------------------------------------------------------------------
// sbfd_decoder
// command text match and mode flag suppression
// ----------------------------------------------------------------------------
module sbfd_decoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  sbfd_pkg::frame_info_t info,
    output sbfd_pkg::event_info_t ev
);
    import sbfd_pkg::*;

    logic [5:0] mode_flags_reg, mode_flags_next;
    logic       len_two, len_atleast2, len_atleast3;
    logic       is_on, is_off;
    logic [7:0] h0, h1;

    assign h0           = info.head[0];
    assign h1           = info.head[1];
    assign len_two      = info.text_length == 8'd2;
    assign len_atleast2 = info.text_length >= 8'd2;
    assign len_atleast3 = info.text_length >= 8'd3;
    assign is_on        = len_atleast3 && info.head[2] == CH_ON;
    assign is_off       = len_atleast3 && info.head[2] == CH_OFF;

    always_comb
    begin
        logic [2:0] bit_sel;
        event_t on_code;
        logic toggle;
        mode_flags_next = mode_flags_reg;
        ev.valid        = 1'b0;
        ev.code         = EV_UNKNOWN;
        bit_sel         = 3'(FLAG_REPEAT);
        on_code         = EV_REPEAT_ON;
        toggle          = 1'b0;
        if (len_two && h0 == CH_N && h1 == CH_T)
        begin
            ev.valid = 1'b1;
            ev.code  = EV_NEXT_TRACK;
        end
        else if (len_two && h0 == CH_P && h1 == CH_T)
        begin
            ev.valid = 1'b1;
            ev.code  = EV_PREV_TRACK;
        end
        else if (len_two && h0 == CH_P && h1 == CH_L)
        begin
            if (!mode_flags_reg[FLAG_PLAY])
            begin
                ev.valid                  = 1'b1;
                ev.code                   = EV_PLAY;
                mode_flags_next[FLAG_PLAY] = 1'b1;
            end
        end
        else if (len_two && h0 == CH_S && h1 == CH_T)
        begin
            if (mode_flags_reg[FLAG_PLAY])
            begin
                ev.valid                  = 1'b1;
                ev.code                   = EV_STOP;
                mode_flags_next[FLAG_PLAY] = 1'b0;
            end
        end
        else if (len_atleast2 && h0 == CH_R && h1 == CH_P)
        begin
            toggle  = 1'b1;
            bit_sel = 3'(FLAG_REPEAT);
            on_code = EV_REPEAT_ON;
        end
        else if (len_atleast2 && h0 == CH_M && h1 == CH_X)
        begin
            toggle  = 1'b1;
            bit_sel = 3'(FLAG_SHUFFLE);
            on_code = EV_SHUFFLE_ON;
        end
        else if (len_atleast2 && h0 == CH_F && h1 == CH_F)
        begin
            toggle  = 1'b1;
            bit_sel = 3'(FLAG_FF);
            on_code = EV_FF_ON;
        end
        else if (len_atleast2 && h0 == CH_F && h1 == CH_R)
        begin
            toggle  = 1'b1;
            bit_sel = 3'(FLAG_RW);
            on_code = EV_RW_ON;
        end
        else if (len_atleast2 && h0 == CH_S && h1 == CH_C)
        begin
            toggle  = 1'b1;
            bit_sel = 3'(FLAG_SCAN);
            on_code = EV_SCAN_ON;
        end
        else if (len_two && h0 == CH_P && h1 == CH_D)
        begin
            ev.valid = 1'b1;
            ev.code  = EV_PREV_DISC;
        end
        else if (len_two && h0 == CH_N && h1 == CH_D)
        begin
            ev.valid = 1'b1;
            ev.code  = EV_NEXT_DISC;
        end
        else
        begin
            ev.valid = 1'b1;
            ev.code  = EV_UNKNOWN;
        end

        // toggle only fires when the flag changes
        if (toggle)
        begin
            if (is_on && !mode_flags_reg[bit_sel])
            begin
                ev.valid                 = 1'b1;
                ev.code                  = on_code;
                mode_flags_next[bit_sel] = 1'b1;
            end
            else if (is_off && mode_flags_reg[bit_sel])
            begin
                ev.valid                 = 1'b1;
                ev.code                  = event_t'(on_code + 5'd1);
                mode_flags_next[bit_sel] = 1'b0;
            end
        end

        if (!info.done)
        begin
            ev.valid        = 1'b0;
            mode_flags_next = mode_flags_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_flags_reg <= 6'd0;
        end
        else if (step)
        begin
            mode_flags_reg <= mode_flags_next;
        end
    end

endmodule

/* hw/rtl/serial_button_frame_decoder_core.sv */
// ----------------------------------------------------------------------------
// serial_button_frame_decoder_core
// decodes framed serial text commands into button event codes
// ----------------------------------------------------------------------------
// One received byte per request on the slave stream; a byte of 0xff restarts
// framing, the next byte gives the payload length (zero or above
// MAX_FRAME_LENGTH drops the frame) and the last payload byte yields at most
// one event code on the master stream (16 for an unknown command). Each byte
// sits in the input register, passes framing and command matching in one
// step and lands in the result register, so a new byte is taken every cycle
// while the result side keeps up.
module serial_button_frame_decoder_core #(
    parameter int MAX_FRAME_LENGTH = sbfd_pkg::DEF_MAX_FRAME_LENGTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [4:0] event_code, [7:5] zero
);
    import sbfd_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    event_t      out_code_reg;
    logic        out_free;
    logic        step;
    frame_info_t info;
    event_info_t ev;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, out_code_reg};

    sbfd_framer #(
        .MAX_FRAME_LENGTH(MAX_FRAME_LENGTH)
    ) u_framer (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .rx_byte(in_byte_reg),
        .info   (info)
    );

    sbfd_decoder u_decoder (
        .clk  (clk),
        .rst_n(rst_n),
        .step (step),
        .info (info),
        .ev   (ev)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end
            if (step)
            begin
                out_valid_reg <= ev.valid;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (step && ev.valid)
        begin
            out_code_reg <= ev.code;
        end
    end

`ifndef SYNTHESIS
    a_code_range : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[4:0] <= EV_UNKNOWN) && (m_axis_tdata[7:5] == 3'd0))
        else $error("event code out of range");

    a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while pipeline is full");

    a_start_no_event : assert property (@(posedge clk) disable iff (!rst_n)
        (step && in_byte_reg == START_BYTE) |=> !out_valid_reg)
        else $error("start byte produced an event");

    a_event_needs_frame_end : assert property (@(posedge clk) disable iff (!rst_n)
        (step && !info.done) |=> !out_valid_reg)
        else $error("event without frame end");
`endif

endmodule
